@@ rtl/core/lfhs_pkg.sv @@
package lfhs_pkg;

	localparam int DUTY_BITS = 16;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_DUTY  = 2'd1,
		CMD_START = 2'd2,
		CMD_STOP  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_DRILL  = 3'd1,
		PH_CUT    = 3'd2,
		PH_FOLLOW = 3'd3,
		PH_BACK   = 3'd4
	} phase_t;

	// Register indexes on the configuration port (byte address = 4 * index)
	localparam logic [1:0] REG_DRILL_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_CUT_TIMEOUT   = 2'd1;
	localparam logic [1:0] REG_BACK_DELAY    = 2'd2;

	localparam logic [15:0] DRILL_TIMEOUT_RST = 16'd1000;
	localparam logic [15:0] CUT_TIMEOUT_RST   = 16'd1000;
	localparam logic [15:0] BACK_DELAY_RST    = 16'd200;

	typedef struct packed {
		phase_t                 phase;
		logic [15:0]            wait_count;
		logic [DUTY_BITS-1:0]   req_duty;
		logic [DUTY_BITS-1:0]   driven_duty;
		logic                   gate;
		logic                   follow;
	} seq_state_t;

	typedef struct packed {
		logic [15:0] drill_timeout;
		logic [15:0] cut_timeout;
		logic [15:0] back_delay;
	} seq_cfg_t;

	typedef struct packed {
		logic alarm;
		logic done;
		logic success;
		logic rejected;
	} seq_flags_t;

	typedef struct packed {
		logic [15:0] pwm_duty;
		logic        follow_out;
		logic        laser_enabled;
		phase_t      phase;
		seq_flags_t  flags;
	} seq_result_t;

endpackage

@@ rtl/core/laser_follow_head_sequencer_core.sv @@
// Laser follow-head sequencer.
//
// Input channel (in_valid/in_ready) carries one item per transfer: cmd selects
// a millisecond tick, a duty request, a follow start or a follow stop, with
// duty, drill_ready and cut_ready alongside. Every input transfer yields
// exactly one output transfer (out_valid/out_ready) carrying the driven PWM
// duty, follow and laser gate levels, the phase and the alarm, done, success
// and rejected pulses, all taken after the item has been applied.
// The item is held in an input stage, the state update and result are computed
// from it in one pass and registered at the output. Throughput is one item per
// cycle while the receiver does not stall; the state register feedback through
// the single next-state pass is what sets that figure.
// When the receiver stalls, the result is held in the output register and
// the input stage may still take one more transfer; after that in_ready drops.
// Reset (arst_n low) returns the sequencer to idle with follow dropped, gate
// closed, zero duty, and loads the default timeouts and back delay.
// Registers over the APB-style port: drill_timeout at 0x0, cut_timeout at
// 0x4, back_delay at 0x8; write only while no transfer is in flight.
module laser_follow_head_sequencer_core (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [15:0] duty,
	input  logic        drill_ready,
	input  logic        cut_ready,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] pwm_duty,
	output logic        follow_out,
	output logic        laser_enabled,
	output logic [2:0]  phase,
	output logic        alarm,
	output logic        done_res,
	output logic        success,
	output logic        rejected,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic                  valid_s1;
	lfhs_pkg::cmd_t        cmd_s1;
	logic [15:0]           duty_s1;
	logic                  drill_s1;
	logic                  cut_s1;

	lfhs_pkg::seq_state_t  state_q;
	lfhs_pkg::seq_state_t  state_nxt;
	lfhs_pkg::seq_flags_t  flags_nxt;
	lfhs_pkg::seq_cfg_t    cfg_q;

	logic                  out_valid_q;
	lfhs_pkg::seq_result_t res_q;

	logic                  advance;
	logic                  in_xfer;
	logic                  cfg_wr;

	// Configuration port: always ready, write on the access phase
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drill_timeout <= lfhs_pkg::DRILL_TIMEOUT_RST;
			cfg_q.cut_timeout   <= lfhs_pkg::CUT_TIMEOUT_RST;
			cfg_q.back_delay    <= lfhs_pkg::BACK_DELAY_RST;
		end else if (cfg_wr) begin
			// Drop writes to addresses beyond the register list
			case (paddr[3:2])
				lfhs_pkg::REG_DRILL_TIMEOUT: cfg_q.drill_timeout <= pwdata[15:0];
				lfhs_pkg::REG_CUT_TIMEOUT:   cfg_q.cut_timeout   <= pwdata[15:0];
				lfhs_pkg::REG_BACK_DELAY:    cfg_q.back_delay    <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			lfhs_pkg::REG_DRILL_TIMEOUT: prdata = {16'd0, cfg_q.drill_timeout};
			lfhs_pkg::REG_CUT_TIMEOUT:   prdata = {16'd0, cfg_q.cut_timeout};
			lfhs_pkg::REG_BACK_DELAY:    prdata = {16'd0, cfg_q.back_delay};
			default:                     prdata = '0;
		endcase
	end

	// Advance the input stage whenever the output register is free or drains
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_xfer  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input stage payload: hold while stalled
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_s1   <= lfhs_pkg::cmd_t'(cmd);
			duty_s1  <= duty;
			drill_s1 <= drill_ready;
			cut_s1   <= cut_ready;
		end
	end

	lfhs_step u_step (
		.cur         (state_q),
		.cfg         (cfg_q),
		.cmd         (cmd_s1),
		.duty        (duty_s1),
		.drill_ready (drill_s1),
		.cut_ready   (cut_s1),
		.nxt         (state_nxt),
		.flags       (flags_nxt)
	);

	// Commit the state only when the item moves into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase       <= lfhs_pkg::PH_IDLE;
			state_q.wait_count  <= '0;
			state_q.req_duty    <= '0;
			state_q.driven_duty <= '0;
			state_q.gate        <= 1'b0;
			state_q.follow      <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.pwm_duty      <= 16'(state_nxt.driven_duty);
			res_q.follow_out    <= state_nxt.follow;
			res_q.laser_enabled <= state_nxt.gate;
			res_q.phase         <= state_nxt.phase;
			res_q.flags         <= flags_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign pwm_duty      = res_q.pwm_duty;
	assign follow_out    = res_q.follow_out;
	assign laser_enabled = res_q.laser_enabled;
	assign phase         = res_q.phase;
	assign alarm         = res_q.flags.alarm;
	assign done_res      = res_q.flags.done;
	assign success       = res_q.flags.success;
	assign rejected      = res_q.flags.rejected;

	// A rejected command never completes a sequence
	a_reject_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.flags.rejected |-> !res_q.flags.done)
		else $error("rejected command reported a completion");

	// A timeout fails the sequence and leaves the head idle with zero duty
	a_alarm_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.flags.alarm |-> res_q.flags.done && !res_q.flags.success
		&& (res_q.phase == lfhs_pkg::PH_IDLE) && (res_q.pwm_duty == 16'd0))
		else $error("alarm without failed completion to idle");

	// The gate is only open while follow is raised
	a_gate_follow: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.gate |-> state_q.follow)
		else $error("laser gate open with follow dropped");

	// With the gate closed no duty reaches the output
	a_closed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.gate |-> (state_q.driven_duty == '0))
		else $error("duty driven while laser gate closed");

	// Following always has the gate open
	a_follow_gate: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == lfhs_pkg::PH_FOLLOW) |-> state_q.gate)
		else $error("following with laser gate closed");

endmodule

@@ rtl/core/lfhs_step.sv @@
// Next-state logic for one item: applies the command to the sequencer state.
module lfhs_step (
	input  lfhs_pkg::seq_state_t  cur,
	input  lfhs_pkg::seq_cfg_t    cfg,
	input  lfhs_pkg::cmd_t        cmd,
	input  logic [15:0]           duty,
	input  logic                  drill_ready,
	input  logic                  cut_ready,
	output lfhs_pkg::seq_state_t  nxt,
	output lfhs_pkg::seq_flags_t  flags
);

	logic [lfhs_pkg::DUTY_BITS-1:0] duty_w;
	logic [16:0]                    cnt_inc;
	logic [15:0]                    back_cnt;
	logic                           busy;
	logic                           enter_cut;
	logic                           reach_follow;
	logic                           fail;
	logic                           back_chk;

	assign duty_w   = lfhs_pkg::DUTY_BITS'(duty);
	assign cnt_inc  = {1'b0, cur.wait_count} + 17'd1;
	// Saturate the back-off count at its full range
	assign back_cnt = (&cur.wait_count) ? cur.wait_count : cnt_inc[15:0];
	assign busy     = (cur.phase == lfhs_pkg::PH_DRILL) || (cur.phase == lfhs_pkg::PH_CUT)
		|| (cur.phase == lfhs_pkg::PH_BACK);

	always_comb begin
		nxt          = cur;
		flags        = '0;
		enter_cut    = 1'b0;
		reach_follow = 1'b0;
		fail         = 1'b0;
		back_chk     = 1'b0;

		unique case (cmd)
			lfhs_pkg::CMD_TICK: begin
				case (cur.phase)
					lfhs_pkg::PH_DRILL: begin
						if (drill_ready) begin
							enter_cut = 1'b1;
						end else if (cnt_inc > {1'b0, cfg.drill_timeout}) begin
							fail = 1'b1;
						end else begin
							nxt.wait_count = cnt_inc[15:0];
						end
					end
					lfhs_pkg::PH_CUT: begin
						if (cut_ready) begin
							reach_follow = 1'b1;
						end else if (cnt_inc > {1'b0, cfg.cut_timeout}) begin
							fail = 1'b1;
						end else begin
							nxt.wait_count = cnt_inc[15:0];
						end
					end
					lfhs_pkg::PH_BACK: begin
						nxt.wait_count = back_cnt;
						back_chk       = 1'b1;
					end
					default: begin
					end
				endcase
			end
			lfhs_pkg::CMD_DUTY: begin
				if (duty_w != cur.req_duty) begin
					nxt.req_duty = duty_w;
					if (cur.gate || (duty_w == '0)) begin
						nxt.driven_duty = duty_w;
					end
				end
			end
			lfhs_pkg::CMD_START: begin
				if (busy) begin
					flags.rejected = 1'b1;
				end else begin
					nxt.follow     = 1'b1;
					nxt.phase      = lfhs_pkg::PH_DRILL;
					nxt.wait_count = '0;
					enter_cut      = drill_ready;
				end
			end
			lfhs_pkg::CMD_STOP: begin
				if (busy) begin
					flags.rejected = 1'b1;
				end else begin
					nxt.gate        = 1'b0;
					nxt.driven_duty = '0;
					nxt.follow      = 1'b0;
					nxt.phase       = lfhs_pkg::PH_BACK;
					nxt.wait_count  = '0;
					back_chk        = 1'b1;
				end
			end
		endcase

		// Drill position reached: open the gate and go on to check cut-ready
		if (enter_cut) begin
			nxt.gate        = 1'b1;
			nxt.driven_duty = cur.req_duty;
			nxt.phase       = lfhs_pkg::PH_CUT;
			nxt.wait_count  = '0;
			reach_follow    = cut_ready;
		end
		if (reach_follow) begin
			nxt.phase      = lfhs_pkg::PH_FOLLOW;
			nxt.wait_count = '0;
			flags.done     = 1'b1;
			flags.success  = 1'b1;
		end
		if (fail) begin
			nxt.gate        = 1'b0;
			nxt.driven_duty = '0;
			nxt.follow      = 1'b0;
			nxt.phase       = lfhs_pkg::PH_IDLE;
			nxt.wait_count  = '0;
			flags.alarm     = 1'b1;
			flags.done      = 1'b1;
		end
		if (back_chk && (nxt.wait_count >= cfg.back_delay)) begin
			nxt.phase      = lfhs_pkg::PH_IDLE;
			nxt.wait_count = '0;
			flags.done     = 1'b1;
			flags.success  = 1'b1;
		end
	end

endmodule

@@ tb/tb_laser_follow_head_sequencer_core.sv @@
module tb_laser_follow_head_sequencer_core;
	timeunit 1ns;
	timeprecision 1ps;

	import lfhs_pkg::*;

	// Random section: eight register settings, each followed by a run of items
	localparam int SETTINGS_RUNS = 8;
	localparam int RUN_ITEMS     = 92;
	// Receiver hold-off long enough to back the block up into its input stage
	localparam int LONG_HOLD     = 48;
	// Cycles without any transfer before the run is declared hung
	localparam int STALL_LIMIT   = 400;

	typedef struct packed {
		cmd_t        cmd;
		logic [15:0] duty;
		logic        drill;
		logic        cut;
	} head_item_t;

	// One line of the directed script: either a register write or an item,
	// the item optionally carrying a hand-written result
	typedef struct {
		bit          is_cfg;
		logic [1:0]  reg_idx;
		logic [15:0] reg_val;
		head_item_t  item;
		bit          pinned;
		seq_result_t want;
	} script_row_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd         = CMD_TICK;
	logic [15:0] duty        = '0;
	logic        drill_ready = 1'b0;
	logic        cut_ready   = 1'b0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	logic [15:0] pwm_duty;
	logic        follow_out;
	logic        laser_enabled;
	logic [2:0]  phase;
	logic        alarm;
	logic        done_res;
	logic        success;
	logic        rejected;
	logic        psel        = 1'b0;
	logic        penable     = 1'b0;
	logic        pwrite      = 1'b0;
	logic [3:0]  paddr       = '0;
	logic [31:0] pwdata      = '0;
	logic [31:0] prdata;
	logic        pready;

	laser_follow_head_sequencer_core uut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow of the sequencer: its registers, state and the results still owed
	logic [15:0] lim_drill = DRILL_TIMEOUT_RST;
	logic [15:0] lim_cut   = CUT_TIMEOUT_RST;
	logic [15:0] lim_back  = BACK_DELAY_RST;
	phase_t      st_phase  = PH_IDLE;
	logic [15:0] st_wait   = '0;
	logic [15:0] st_req    = '0;
	logic [15:0] st_driven = '0;
	logic        st_gate   = 1'b0;
	logic        st_follow = 1'b0;

	seq_result_t pending_results[$];
	int          mismatches   = 0;
	int          results_seen = 0;
	bit          calm         = 1'b0;	// both sides stream without random gaps

	// --- sequencer shadow ---------------------------------------------------

	// Timed-out wait: drop follow, close the gate, zero the output, flag failure
	function automatic void abort_sequence(inout seq_flags_t f);
		st_gate   = 1'b0;
		st_driven = '0;
		st_follow = 1'b0;
		st_phase  = PH_IDLE;
		st_wait   = '0;
		f.alarm   = 1'b1;
		f.done    = 1'b1;
		f.success = 1'b0;
	endfunction

	function automatic void await_cut(input logic cut, input logic tick, inout seq_flags_t f);
		logic [16:0] n;
		if (cut) begin
			st_phase  = PH_FOLLOW;
			st_wait   = '0;
			f.done    = 1'b1;
			f.success = 1'b1;
		end else if (tick) begin
			n = {1'b0, st_wait} + 17'd1;
			if (n > {1'b0, lim_cut})
				abort_sequence(f);
			else
				st_wait = n[15:0];
		end
	endfunction

	function automatic void await_drill(input logic drill, input logic cut, input logic tick,
			inout seq_flags_t f);
		logic [16:0] n;
		if (drill) begin
			// Pierce position reached: open the gate and let the stored duty through
			st_gate   = 1'b1;
			st_driven = st_req;
			st_phase  = PH_CUT;
			st_wait   = '0;
			await_cut(cut, 1'b0, f);
		end else if (tick) begin
			n = {1'b0, st_wait} + 17'd1;
			if (n > {1'b0, lim_drill})
				abort_sequence(f);
			else
				st_wait = n[15:0];
		end
	endfunction

	function automatic void finish_back(inout seq_flags_t f);
		if (st_wait >= lim_back) begin
			st_phase  = PH_IDLE;
			st_wait   = '0;
			f.done    = 1'b1;
			f.success = 1'b1;
		end
	endfunction

	// Apply one item to the shadow state and return the result it must produce
	function automatic seq_result_t step_sequencer(head_item_t it);
		seq_result_t r;
		seq_flags_t  f;
		logic [16:0] n;
		bit          busy;
		f    = '0;
		busy = (st_phase == PH_DRILL) || (st_phase == PH_CUT) || (st_phase == PH_BACK);
		case (it.cmd)
			CMD_TICK: begin
				if (st_phase == PH_DRILL)
					await_drill(it.drill, it.cut, 1'b1, f);
				else if (st_phase == PH_CUT)
					await_cut(it.cut, 1'b1, f);
				else if (st_phase == PH_BACK) begin
					// Saturate the back-off count at the top of its range
					n       = {1'b0, st_wait} + 17'd1;
					st_wait = n[16] ? 16'hFFFF : n[15:0];
					finish_back(f);
				end
			end
			CMD_DUTY: begin
				if (it.duty != st_req) begin
					st_req = it.duty;
					if (st_gate || it.duty == '0)
						st_driven = it.duty;
				end
			end
			default: begin
				if (busy)
					f.rejected = 1'b1;
				else if (it.cmd == CMD_START) begin
					st_follow = 1'b1;
					st_phase  = PH_DRILL;
					st_wait   = '0;
					await_drill(it.drill, it.cut, 1'b0, f);
				end else begin
					st_gate   = 1'b0;
					st_driven = '0;
					st_follow = 1'b0;
					st_phase  = PH_BACK;
					st_wait   = '0;
					finish_back(f);
				end
			end
		endcase
		r.pwm_duty      = st_driven;
		r.follow_out    = st_follow;
		r.laser_enabled = st_gate;
		r.phase         = st_phase;
		r.flags         = f;
		return r;
	endfunction

	// --- script helpers -----------------------------------------------------

	function automatic head_item_t mk_item(cmd_t c, logic [15:0] d, logic dr, logic cu);
		head_item_t it;
		it.cmd   = c;
		it.duty  = d;
		it.drill = dr;
		it.cut   = cu;
		return it;
	endfunction

	function automatic seq_result_t mk_res(logic [15:0] pwm, logic fol, logic gate, phase_t ph,
			logic alm, logic dn, logic ok, logic rej);
		seq_result_t r;
		r.pwm_duty       = pwm;
		r.follow_out     = fol;
		r.laser_enabled  = gate;
		r.phase          = ph;
		r.flags.alarm    = alm;
		r.flags.done     = dn;
		r.flags.success  = ok;
		r.flags.rejected = rej;
		return r;
	endfunction

	function automatic script_row_t as_row(head_item_t it);
		script_row_t row;
		row        = '{default: '0};
		row.item   = it;
		return row;
	endfunction

	function automatic script_row_t pinned_row(head_item_t it, seq_result_t want);
		script_row_t row;
		row        = as_row(it);
		row.pinned = 1'b1;
		row.want   = want;
		return row;
	endfunction

	function automatic script_row_t cfg_row(logic [1:0] idx, logic [15:0] val);
		script_row_t row;
		row         = '{default: '0};
		row.is_cfg  = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		return row;
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
	endfunction

	function automatic int sender_gap();
		if (calm || $urandom_range(0, 1) == 0)
			return 0;
		return pick_gap();
	endfunction

	function automatic logic [15:0] pick_timeout();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return 16'd0;
		if (r == 1)
			return 16'hFFFF;
		return 16'($urandom_range(1, 6));
	endfunction

	// Steer the random items by the shadow phase so that most runs walk a
	// whole start, follow, stop cycle; the rest are rejects and stray ticks
	function automatic head_item_t draw_item();
		head_item_t it;
		int         r;
		int         dsel;
		r    = $urandom_range(0, 99);
		dsel = $urandom_range(0, 7);
		it.duty  = (dsel == 0) ? 16'h0000 :
			(dsel == 1) ? 16'hFFFF :
			(dsel == 2) ? st_req : 16'($urandom_range(0, 65535));
		it.drill = 1'($urandom_range(0, 1));
		it.cut   = 1'($urandom_range(0, 1));
		case (st_phase)
			PH_IDLE:
				it.cmd = (r < 40) ? CMD_START : (r < 55) ? CMD_STOP :
					(r < 80) ? CMD_DUTY : CMD_TICK;
			PH_DRILL, PH_CUT: begin
				it.cmd   = (r < 75) ? CMD_TICK : (r < 88) ? CMD_DUTY :
					(r < 94) ? CMD_START : CMD_STOP;
				it.drill = ($urandom_range(0, 3) == 0);
				it.cut   = ($urandom_range(0, 3) == 0);
			end
			PH_FOLLOW:
				it.cmd = (r < 30) ? CMD_TICK : (r < 60) ? CMD_DUTY :
					(r < 85) ? CMD_STOP : CMD_START;
			default:
				it.cmd = (r < 80) ? CMD_TICK : (r < 90) ? CMD_DUTY :
					(r < 95) ? CMD_START : CMD_STOP;
		endcase
		return it;
	endfunction

	// --- driving ------------------------------------------------------------

	// Predict the item's result, then offer it until the input transfer happens
	task automatic offer(head_item_t it, bit pinned, seq_result_t want);
		seq_result_t forecast;
		int          gap;
		forecast = step_sequencer(it);
		pending_results.push_back(pinned ? want : forecast);
		gap = sender_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		cmd         <= it.cmd;
		duty        <= it.duty;
		drill_ready <= it.drill;
		cut_ready   <= it.cut;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop valid and wait until every owed result has come back
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Write a register, read it straight back, and update the shadow copy
	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'h0000, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		// Turn the access edge straight into the setup of the read-back
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {16'h0000, val}) begin
			mismatches++;
			$display("%0t: register %0d read back expected %0h actual %0h",
				$time, idx, {16'h0000, val}, prdata);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_DRILL_TIMEOUT: lim_drill = val;
			REG_CUT_TIMEOUT:   lim_cut   = val;
			default:           lim_back  = val;
		endcase
		@(posedge clk);
	endtask

	// --- result side --------------------------------------------------------

	function automatic void cmp_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endfunction

	task automatic take_result();
		seq_result_t want;
		results_seen++;
		if (pending_results.size() == 0) begin
			mismatches++;
			$display("%0t: result transfer with nothing owed, expected none actual phase %0d",
				$time, phase);
		end else begin
			want = pending_results.pop_front();
			cmp_field("pwm_duty", want.pwm_duty, pwm_duty);
			cmp_field("follow_out", 16'(want.follow_out), 16'(follow_out));
			cmp_field("laser_enabled", 16'(want.laser_enabled), 16'(laser_enabled));
			cmp_field("phase", 16'(want.phase), 16'(phase));
			cmp_field("alarm", 16'(want.flags.alarm), 16'(alarm));
			cmp_field("done_res", 16'(want.flags.done), 16'(done_res));
			cmp_field("success", 16'(want.flags.success), 16'(success));
			cmp_field("rejected", 16'(want.flags.rejected), 16'(rejected));
		end
	endtask

	// Receiver: check each output transfer, stall at random, and twice hold
	// off for a long stretch so the input stage fills and in_ready drops
	initial begin : result_sink
		int stall_left;
		int next_hold;
		stall_left = 0;
		next_hold  = 250;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				take_result();
			if (stall_left > 0)
				stall_left--;
			else if (results_seen >= next_hold) begin
				stall_left = LONG_HOLD;
				next_hold  = next_hold + 300;
			end else if (!calm && $urandom_range(0, 3) == 0)
				stall_left = pick_gap();
			out_ready <= (stall_left == 0);
		end
	end

	// Watchdog: end the run if no transfer moves on either channel for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("laser_follow_head_sequencer_core regression: fail");
		$finish;
	end

	// --- stimulus -----------------------------------------------------------

	initial begin : stimulus
		script_row_t script[$];
		logic [15:0] back_val;

		// Reset defaults first: idle tick, duty held back by the closed gate,
		// start with the head not ready, then a tick that finds both ready
		script.push_back(pinned_row(mk_item(CMD_TICK, 16'h0000, 1'b1, 1'b1),
			mk_res(16'h0000, 1'b0, 1'b0, PH_IDLE, 1'b0, 1'b0, 1'b0, 1'b0)));
		script.push_back(pinned_row(mk_item(CMD_DUTY, 16'hFFFF, 1'b0, 1'b0),
			mk_res(16'h0000, 1'b0, 1'b0, PH_IDLE, 1'b0, 1'b0, 1'b0, 1'b0)));
		script.push_back(pinned_row(mk_item(CMD_START, 16'h0000, 1'b0, 1'b0),
			mk_res(16'h0000, 1'b1, 1'b0, PH_DRILL, 1'b0, 1'b0, 1'b0, 1'b0)));
		script.push_back(as_row(mk_item(CMD_TICK, 16'h0000, 1'b1, 1'b1)));
		// Gate open: zero, a new value, and the same value again
		script.push_back(as_row(mk_item(CMD_DUTY, 16'h0000, 1'b0, 1'b0)));
		script.push_back(as_row(mk_item(CMD_DUTY, 16'h0001, 1'b0, 1'b0)));
		script.push_back(as_row(mk_item(CMD_DUTY, 16'h0001, 1'b0, 1'b0)));
		script.push_back(as_row(mk_item(CMD_TICK, 16'hFFFF, 1'b0, 1'b0)));
		// Stop with the default back delay, then commands refused while backing off
		script.push_back(as_row(mk_item(CMD_STOP, 16'h0000, 1'b0, 1'b0)));
		script.push_back(pinned_row(mk_item(CMD_START, 16'h0000, 1'b1, 1'b1),
			mk_res(16'h0000, 1'b0, 1'b0, PH_BACK, 1'b0, 1'b0, 1'b0, 1'b1)));
		script.push_back(pinned_row(mk_item(CMD_STOP, 16'h0000, 1'b0, 1'b0),
			mk_res(16'h0000, 1'b0, 1'b0, PH_BACK, 1'b0, 1'b0, 1'b0, 1'b1)));
		script.push_back(as_row(mk_item(CMD_DUTY, 16'h8000, 1'b0, 1'b0)));
		// Tight limits; the back delay drops to zero, so the next tick ends the back-off
		script.push_back(cfg_row(REG_DRILL_TIMEOUT, 16'd0));
		script.push_back(cfg_row(REG_CUT_TIMEOUT, 16'd1));
		script.push_back(cfg_row(REG_BACK_DELAY, 16'd0));
		script.push_back(as_row(mk_item(CMD_TICK, 16'h0000, 1'b0, 1'b0)));
		// Zero drill timeout alarms on the first tick without the head ready
		script.push_back(as_row(mk_item(CMD_START, 16'h0000, 1'b0, 1'b0)));
		script.push_back(pinned_row(mk_item(CMD_TICK, 16'h0000, 1'b0, 1'b0),
			mk_res(16'h0000, 1'b0, 1'b0, PH_IDLE, 1'b1, 1'b1, 1'b0, 1'b0)));
		// Start item itself finds drill-ready; cut times out on the second tick
		script.push_back(as_row(mk_item(CMD_START, 16'h0000, 1'b1, 1'b0)));
		script.push_back(as_row(mk_item(CMD_TICK, 16'h0000, 1'b1, 1'b0)));
		script.push_back(pinned_row(mk_item(CMD_TICK, 16'h0000, 1'b1, 1'b0),
			mk_res(16'h0000, 1'b0, 1'b0, PH_IDLE, 1'b1, 1'b1, 1'b0, 1'b0)));
		// Zero back delay: stop completes on the stop item
		script.push_back(pinned_row(mk_item(CMD_STOP, 16'h0000, 1'b0, 1'b0),
			mk_res(16'h0000, 1'b0, 1'b0, PH_IDLE, 1'b0, 1'b1, 1'b1, 1'b0)));
		// Full start on one item, then restart while following
		script.push_back(as_row(mk_item(CMD_START, 16'h0000, 1'b1, 1'b1)));
		script.push_back(as_row(mk_item(CMD_TICK, 16'h0000, 1'b0, 1'b0)));
		script.push_back(as_row(mk_item(CMD_START, 16'h0000, 1'b0, 1'b1)));
		script.push_back(as_row(mk_item(CMD_TICK, 16'h0000, 1'b1, 1'b1)));
		script.push_back(as_row(mk_item(CMD_STOP, 16'hFFFF, 1'b1, 1'b1)));

		// Hold reset, then release it on a rising edge
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].is_cfg) begin
				settle();
				write_reg(script[i].reg_idx, script[i].reg_val);
			end else
				offer(script[i].item, script[i].pinned, script[i].want);
		end

		// Random runs: the first with the widest limits, the last with the
		// longest back delay, every third one without random gaps
		for (int run = 0; run < SETTINGS_RUNS; run++) begin
			settle();
			calm <= (run % 3 == 2);
			back_val = 16'($urandom_range(0, 5));
			if (run == 0) begin
				write_reg(REG_DRILL_TIMEOUT, 16'hFFFF);
				write_reg(REG_CUT_TIMEOUT, 16'hFFFF);
				write_reg(REG_BACK_DELAY, 16'd2);
			end else begin
				write_reg(REG_DRILL_TIMEOUT, pick_timeout());
				write_reg(REG_CUT_TIMEOUT, pick_timeout());
				write_reg(REG_BACK_DELAY, (run == SETTINGS_RUNS - 1) ? 16'hFFFF : back_val);
			end
			repeat (RUN_ITEMS)
				offer(draw_item(), 1'b0, '0);
		end

		// Drain, allow the pipeline to go quiet, then report
		settle();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("laser_follow_head_sequencer_core regression: pass");
		else
			$display("laser_follow_head_sequencer_core regression: fail");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/lfhs_pkg.sv
rtl/core/lfhs_step.sv
rtl/core/laser_follow_head_sequencer_core.sv
tb/tb_laser_follow_head_sequencer_core.sv
